### rtl/dra_pkg.sv
// shared types and codes for the descriptor range allocator
// no dependencies; imported by every module of the block
package dra_pkg;

  localparam int DIV_STEPS = 32;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RELEASE = 2'd2
  } dra_cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_FULL    = 2'd2
  } dra_status_e;

  typedef enum logic [1:0] {
    CFG_HEAP   = 2'd0,
    CFG_BASE   = 2'd1,
    CFG_STRIDE = 2'd2
  } dra_cfg_e;

  typedef enum logic [3:0] {
    OP_NOP, OP_CLR_START, OP_CLR, OP_LATCH, OP_SCAN, OP_ALOC_WR, OP_DIV, OP_PUSH,
    OP_HEAD_RD, OP_REL_INIT, OP_WR_PREV, OP_WR_NEXT, OP_WR_SPARE, OP_POP, OP_RESULT
  } dra_op_e;

  typedef enum logic [3:0] {
    S_CLR0, S_CLR, S_IDLE, S_DISPATCH, S_SCAN, S_ALOC_WR, S_DIV, S_PUSH,
    S_HEAD_RD, S_CHECK, S_WR_PREV, S_WR_NEXT, S_WR_SPARE, S_POP, S_RESULT
  } dra_state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [10:0] count;
    logic [63:0] handle_in;
    logic [63:0] frame;
  } dra_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  slot_offset;
    logic [63:0] handle_out;
    logic [10:0] free_total;
    logic [8:0]  released;
  } dra_result_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       idx_end;
    logic       div_done;
    logic       due;
    logic       rel_ok;
    logic       overlap;
    logic       spare_any;
  } dra_stat_t;

endpackage

### rtl/dra_ctrl.sv
// sequencer of the allocator: walks each item through scan, divide and write steps
// depends on dra_pkg; drives the datapath by one op code per cycle
module dra_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  logic              clr_i,
  input  dra_pkg::dra_stat_t stat_i,
  output dra_pkg::dra_op_e  op_o,
  output logic              busy_o
);
  import dra_pkg::*;

  dra_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR0;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR0:     state_d = S_CLR;
      S_CLR:      if (stat_i.idx_end) state_d = S_IDLE;
      S_IDLE:     if (go_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        case (stat_i.cmd)
          CMD_ALLOC:   state_d = S_SCAN;
          CMD_FREE:    state_d = S_DIV;
          CMD_RELEASE: state_d = S_HEAD_RD;
          default:     state_d = S_RESULT;
        endcase
      end
      S_SCAN: begin
        if (stat_i.idx_end) begin
          if (stat_i.cmd == CMD_ALLOC) state_d = S_ALOC_WR;
          else if (stat_i.overlap || !stat_i.spare_any) state_d = S_POP;
          else state_d = S_WR_PREV;
        end
      end
      S_ALOC_WR:  state_d = S_RESULT;
      S_DIV:      if (stat_i.div_done) state_d = S_PUSH;
      S_PUSH:     state_d = S_RESULT;
      S_HEAD_RD:  state_d = S_CHECK;
      S_CHECK: begin
        if (!stat_i.due) state_d = S_RESULT;
        else if (!stat_i.rel_ok) state_d = S_POP;
        else state_d = S_SCAN;
      end
      S_WR_PREV:  state_d = S_WR_NEXT;
      S_WR_NEXT:  state_d = S_WR_SPARE;
      S_WR_SPARE: state_d = S_POP;
      S_POP:      state_d = S_HEAD_RD;
      S_RESULT:   state_d = S_IDLE;
      default:    state_d = S_CLR0;
    endcase
    // a heap_size write restarts the clearing sweep
    if (clr_i) state_d = S_CLR0;
  end

  always_comb begin
    op_o = OP_NOP;
    unique case (state_q)
      S_CLR0:     op_o = OP_CLR_START;
      S_CLR:      op_o = stat_i.idx_end ? OP_NOP : OP_CLR;
      S_IDLE:     op_o = go_i ? OP_LATCH : OP_NOP;
      S_SCAN:     op_o = OP_SCAN;
      S_ALOC_WR:  op_o = OP_ALOC_WR;
      S_DIV:      op_o = stat_i.div_done ? OP_NOP : OP_DIV;
      S_PUSH:     op_o = OP_PUSH;
      S_HEAD_RD:  op_o = OP_HEAD_RD;
      S_CHECK:    op_o = OP_REL_INIT;
      S_WR_PREV:  op_o = OP_WR_PREV;
      S_WR_NEXT:  op_o = OP_WR_NEXT;
      S_WR_SPARE: op_o = OP_WR_SPARE;
      S_POP:      op_o = OP_POP;
      S_RESULT:   op_o = OP_RESULT;
      default:    op_o = OP_NOP;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### rtl/dra_datapath.sv
// free-block table, stale queue, offset divider and result register
// depends on dra_pkg; steered by dra_ctrl through one op code per cycle
module dra_datapath #(
  parameter int HEAP_CAP        = 1024,
  parameter int MAX_FREE_BLOCKS = 512,
  parameter int STALE_DEPTH     = 256,
  parameter int SW = ($clog2(HEAP_CAP + 1) > 11) ? $clog2(HEAP_CAP + 1) : 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dra_pkg::dra_op_e    op_i,
  input  dra_pkg::dra_item_t  item_i,
  input  logic [SW-1:0]       hs_i,
  input  logic [63:0]         base_i,
  input  logic [8:0]          stride_i,
  output dra_pkg::dra_stat_t  stat_o,
  output dra_pkg::dra_result_t result_o,
  output logic                done_o
);
  import dra_pkg::*;

  localparam int N  = MAX_FREE_BLOCKS;
  localparam int AW = (N > 1) ? $clog2(N) : 1;
  localparam int IW = $clog2(N + 1);
  localparam int PW = $clog2(STALE_DEPTH);
  localparam int UW = $clog2(STALE_DEPTH + 1);

  typedef struct packed {
    logic          v;
    logic [SW-1:0] off;
    logic [SW-1:0] sz;
    logic [31:0]   st;
  } ent_t;

  typedef struct packed {
    logic [SW-1:0] off;
    logic [10:0]   cnt;
    logic [63:0]   frame;
  } sq_t;

  ent_t tbl_mem [N];
  sq_t  sq_mem [STALE_DEPTH];

  // item and control registers
  logic [1:0]    cmd_q;
  logic [10:0]   count_q;
  logic [63:0]   frame_q;
  logic [IW-1:0] idx_q;
  logic          rd_vld_q;
  ent_t          rd_q;
  logic [AW-1:0] rd_idx_q;
  logic [SW-1:0] free_q;
  logic [31:0]   ctr_q;
  logic [PW-1:0] head_q, tail_q;
  logic [UW-1:0] used_q;
  // divider
  logic [31:0]   quo_q;
  logic [8:0]    rem_q, dv_q;
  logic [5:0]    dcnt_q;
  // best fit
  logic          bf_q;
  logic [AW-1:0] b_idx_q;
  logic [SW-1:0] b_off_q, b_sz_q;
  logic [31:0]   b_st_q;
  // release merge
  sq_t           sq_q;
  logic [SW-1:0] roff_q, rcnt_q;
  logic          ov_q, hp_q, hn_q, hsp_q;
  logic [AW-1:0] p_idx_q, n_idx_q, sp_idx_q;
  logic [SW-1:0] p_off_q, p_sz_q, n_sz_q;
  // result
  logic [1:0]    status_q;
  logic [SW-1:0] off_q;
  logic [63:0]   prod_q;
  logic [8:0]    rel_cnt_q;
  dra_result_t   res_q;
  logic          done_q;

  logic [SW-1:0] cnt_s;
  assign cnt_s = SW'(count_q);

  // divider step
  logic [9:0] rsh;
  logic       ge;
  assign rsh = {rem_q, quo_q[31]};
  assign ge  = (rsh >= {1'b0, dv_q});

  // free range check
  logic [32:0] hs33, q33;
  logic        fr_ok;
  assign hs33  = 33'(hs_i);
  assign q33   = {1'b0, quo_q};
  assign fr_ok = (count_q != 11'd0) && (q33 < hs33) && (33'(count_q) <= hs33 - q33);

  // release range check on the head entry
  logic [SW:0] s_end;
  logic        rel_ok;
  assign s_end  = {1'b0, sq_q.off} + (SW + 1)'(sq_q.cnt);
  assign rel_ok = (sq_q.cnt != 11'd0) && (sq_q.off < hs_i) && (s_end <= (SW + 1)'(hs_i));

  // scan evaluation
  logic        cand, better;
  logic [SW:0] e_end, r_end;
  assign cand   = rd_q.v && (rd_q.sz >= cnt_s);
  assign better = !bf_q || (rd_q.sz < b_sz_q) || ((rd_q.sz == b_sz_q) && (rd_q.st < b_st_q));
  assign e_end  = {1'b0, rd_q.off} + {1'b0, rd_q.sz};
  assign r_end  = {1'b0, roff_q} + {1'b0, rcnt_q};

  // allocation
  logic          fit, aloc_ok;
  logic [SW-1:0] rest;
  logic [SW+8:0] mul_w;
  assign fit     = (cnt_s <= free_q);
  assign aloc_ok = fit && bf_q;
  assign rest    = b_sz_q - cnt_s;
  assign mul_w   = {9'd0, b_off_q} * {{SW{1'b0}}, stride_i};

  // spare entry: lowest free index once prev and next are gone
  logic [AW-1:0] sel_idx;
  logic          sel_have;
  logic [SW-1:0] noff, ncnt;
  always_comb begin
    sel_idx  = sp_idx_q;
    sel_have = hsp_q;
    if (hp_q && (!sel_have || p_idx_q < sel_idx)) begin
      sel_idx  = p_idx_q;
      sel_have = 1'b1;
    end
    if (hn_q && (!sel_have || n_idx_q < sel_idx)) begin
      sel_idx  = n_idx_q;
      sel_have = 1'b1;
    end
  end
  assign noff = hp_q ? p_off_q : roff_q;
  assign ncnt = rcnt_q + (hp_q ? p_sz_q : '0) + (hn_q ? n_sz_q : '0);

  logic issue;
  assign issue = (op_i == OP_SCAN) && (idx_q < IW'(N));

  // table write port
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  ent_t          wr_data;
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q[AW-1:0];
    wr_data = '0;
    case (op_i)
      OP_CLR: begin
        wr_en = 1'b1;
        if (idx_q == '0 && hs_i != '0) wr_data = '{v: 1'b1, off: '0, sz: hs_i, st: 32'd0};
      end
      OP_ALOC_WR: begin
        wr_en   = aloc_ok;
        wr_addr = b_idx_q;
        if (rest != '0) wr_data = '{v: 1'b1, off: b_off_q + cnt_s, sz: rest, st: ctr_q};
      end
      OP_WR_PREV: begin
        wr_en   = hp_q;
        wr_addr = p_idx_q;
      end
      OP_WR_NEXT: begin
        wr_en   = hn_q;
        wr_addr = n_idx_q;
      end
      OP_WR_SPARE: begin
        wr_en   = 1'b1;
        wr_addr = sel_idx;
        wr_data = '{v: 1'b1, off: noff, sz: ncnt, st: ctr_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) tbl_mem[wr_addr] <= wr_data;
    if (issue) begin
      rd_q     <= tbl_mem[idx_q[AW-1:0]];
      rd_idx_q <= idx_q[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_PUSH && used_q < UW'(STALE_DEPTH) && fr_ok) begin
      sq_mem[tail_q] <= '{off: SW'(quo_q), cnt: count_q, frame: frame_q};
    end
    if (op_i == OP_HEAD_RD) sq_q <= sq_mem[head_q];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      free_q    <= SW'(HEAP_CAP);
      ctr_q     <= 32'd1;
      head_q    <= '0;
      tail_q    <= '0;
      used_q    <= '0;
      dcnt_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      done_q   <= (op_i == OP_RESULT);
      if (issue || op_i == OP_CLR) idx_q <= idx_q + 1'b1;
      case (op_i)
        OP_CLR_START: begin
          idx_q  <= '0;
          free_q <= hs_i;
          ctr_q  <= 32'd1;
        end
        OP_LATCH: begin
          idx_q  <= '0;
          dcnt_q <= '0;
        end
        OP_REL_INIT: idx_q <= '0;
        OP_DIV: dcnt_q <= dcnt_q + 6'd1;
        OP_ALOC_WR: begin
          if (aloc_ok) begin
            free_q <= free_q - cnt_s;
            if (rest != '0) ctr_q <= ctr_q + 32'd1;
          end
        end
        OP_WR_SPARE: begin
          free_q <= free_q + rcnt_q;
          ctr_q  <= ctr_q + 32'd1;
        end
        OP_PUSH: begin
          if (used_q < UW'(STALE_DEPTH) && fr_ok) begin
            tail_q <= (tail_q == PW'(STALE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
            used_q <= used_q + 1'b1;
          end
        end
        OP_POP: begin
          head_q <= (head_q == PW'(STALE_DEPTH - 1)) ? '0 : head_q + 1'b1;
          used_q <= used_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LATCH: begin
        cmd_q     <= item_i.cmd;
        count_q   <= item_i.count;
        frame_q   <= item_i.frame;
        quo_q     <= 32'(item_i.handle_in - base_i);
        rem_q     <= '0;
        dv_q      <= (stride_i == 9'd0) ? 9'd1 : stride_i;
        bf_q      <= 1'b0;
        status_q  <= ST_OK;
        off_q     <= '0;
        prod_q    <= '0;
        rel_cnt_q <= '0;
      end
      OP_DIV: begin
        rem_q <= ge ? 9'(rsh - {1'b0, dv_q}) : rsh[8:0];
        quo_q <= {quo_q[30:0], ge};
      end
      OP_PUSH: if (used_q >= UW'(STALE_DEPTH)) status_q <= ST_FULL;
      OP_ALOC_WR: begin
        if (aloc_ok) begin
          off_q  <= b_off_q;
          prod_q <= 64'(mul_w);
        end else begin
          status_q <= ST_NOSPACE;
        end
      end
      OP_REL_INIT: begin
        roff_q <= sq_q.off;
        rcnt_q <= SW'(sq_q.cnt);
        ov_q   <= 1'b0;
        hp_q   <= 1'b0;
        hn_q   <= 1'b0;
        hsp_q  <= 1'b0;
      end
      OP_POP: rel_cnt_q <= rel_cnt_q + 9'd1;
      OP_RESULT: begin
        res_q.status      <= status_q;
        res_q.slot_offset <= 10'(off_q);
        res_q.free_total  <= 11'(free_q);
        res_q.released    <= rel_cnt_q;
        // a failed or non-allocating item reports a zero handle
        res_q.handle_out  <= (status_q == ST_OK && cmd_q == CMD_ALLOC) ?
                             base_i + prod_q : '0;
      end
      default: ;
    endcase
    // one table entry judged per beat of the scan
    if (rd_vld_q) begin
      if (cmd_q == CMD_ALLOC) begin
        if (cand && better) begin
          bf_q    <= 1'b1;
          b_idx_q <= rd_idx_q;
          b_off_q <= rd_q.off;
          b_sz_q  <= rd_q.sz;
          b_st_q  <= rd_q.st;
        end
      end else if (rd_q.v) begin
        if (({1'b0, rd_q.off} < r_end) && ({1'b0, roff_q} < e_end)) ov_q <= 1'b1;
        if (!hp_q && e_end == {1'b0, roff_q}) begin
          hp_q    <= 1'b1;
          p_idx_q <= rd_idx_q;
          p_off_q <= rd_q.off;
          p_sz_q  <= rd_q.sz;
        end
        if (!hn_q && {1'b0, rd_q.off} == r_end) begin
          hn_q    <= 1'b1;
          n_idx_q <= rd_idx_q;
          n_sz_q  <= rd_q.sz;
        end
      end else if (!hsp_q) begin
        hsp_q    <= 1'b1;
        sp_idx_q <= rd_idx_q;
      end
    end
  end

  assign stat_o.cmd       = cmd_q;
  assign stat_o.idx_end   = (idx_q == IW'(N)) && !rd_vld_q;
  assign stat_o.div_done  = (dcnt_q == 6'(DIV_STEPS));
  assign stat_o.due       = (used_q != '0) && (sq_q.frame <= frame_q);
  assign stat_o.rel_ok    = rel_ok;
  assign stat_o.overlap   = ov_q;
  assign stat_o.spare_any = hsp_q || hp_q || hn_q;

  assign result_o = res_q;
  assign done_o   = done_q;

endmodule

### rtl/descriptor_range_allocator.sv
// top level of the descriptor range allocator: register port, sequencer, datapath
// depends on dra_pkg, dra_ctrl and dra_datapath
//
// One item at a time: busy is high after the beat that takes an item until its result.
// An allocate is paced by a scan of the free-block table through its single read port,
// a free by the one-bit-a-cycle offset divider. A release reads and checks the head of
// the stale queue and, for each range it returns, does one table scan and up to three
// table writes. After reset and after every heap_size write a clearing sweep runs with
// busy high. The result is shown for one cycle on done_o; the receiver cannot stall it.
module descriptor_range_allocator #(
  parameter int HEAP_CAP        = 1024,
  parameter int MAX_FREE_BLOCKS = 512,
  parameter int STALE_DEPTH     = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  dra_pkg::dra_item_t   item_i,
  output logic                 done_o,
  output dra_pkg::dra_result_t result_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);
  import dra_pkg::*;

  localparam int SW = ($clog2(HEAP_CAP + 1) > 11) ? $clog2(HEAP_CAP + 1) : 11;

  logic [SW-1:0] hs_q;
  logic [63:0]   base_q;
  logic [8:0]    stride_q;
  logic          wr_beat, clr;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_beat = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:3];
  assign clr     = wr_beat && (reg_idx == CFG_HEAP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q     <= SW'(HEAP_CAP);
      base_q   <= '0;
      stride_q <= 9'd32;
    end else if (wr_beat) begin
      unique case (reg_idx)
        CFG_HEAP:   hs_q <= (pwdata > 64'(HEAP_CAP)) ? SW'(HEAP_CAP) : SW'(pwdata);
        CFG_BASE:   base_q <= pwdata;
        CFG_STRIDE: stride_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      CFG_HEAP:   prdata = 64'(hs_q);
      CFG_BASE:   prdata = base_q;
      CFG_STRIDE: prdata = 64'(stride_q);
      default:    prdata = '0;
    endcase
  end

  dra_op_e   op;
  dra_stat_t stat;
  logic      go;

  assign go = start && !busy;

  dra_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .clr_i  (clr),
    .stat_i (stat),
    .op_o   (op),
    .busy_o (busy)
  );

  dra_datapath #(
    .HEAP_CAP        (HEAP_CAP),
    .MAX_FREE_BLOCKS (MAX_FREE_BLOCKS),
    .STALE_DEPTH     (STALE_DEPTH),
    .SW              (SW)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (op),
    .item_i   (item_i),
    .hs_i     (hs_q),
    .base_i   (base_q),
    .stride_i (stride_q),
    .stat_o   (stat),
    .result_o (result_o),
    .done_o   (done_o)
  );

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && !clr |=> busy)
    else $error("accepted beat did not make the block busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status != ST_OK |-> result_o.handle_out == 64'd0 &&
    result_o.released == 9'd0)
    else $error("failed item reported a handle or released ranges");

endmodule
